>>> hw/rtl/qar_pkg.sv
// Shared types and constants for the quadratic audio resampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package qar_pkg;

    localparam int SAMPLE_WIDTH        = 16;
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int MAX_RESULTS         = 8;
    localparam int QUEUE_DEPTH         = 2;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_sample;
        logic signed [SAMPLE_WIDTH-1:0] right_sample;
    } t_in_frame;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
        logic                           last;
    } t_out_frame;

    // Parabola coefficients of one interval: 2a, 2b and the oldest frame.
    typedef struct packed {
        logic                           first;
        logic signed [SAMPLE_WIDTH+1:0] a2_l;
        logic signed [SAMPLE_WIDTH+2:0] b2_l;
        logic signed [SAMPLE_WIDTH-1:0] y0_l;
        logic signed [SAMPLE_WIDTH+1:0] a2_r;
        logic signed [SAMPLE_WIDTH+2:0] b2_r;
        logic signed [SAMPLE_WIDTH-1:0] y0_r;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

>>> hw/rtl/quadratic_audio_resampler.sv
// Top level of the quadratic-interpolation stereo resampler.
// Depends on qar_pkg, qar_front, qar_queue and qar_back.
//
// Usage:
//  - Input channel (i_in_valid/o_in_ready/i_in_data): one stereo frame per
//    request. Output channel (o_out_valid/i_out_ready/o_out_data): one
//    interpolated stereo frame per request, last set on the final frame
//    that an input frame produces (0 to 8 of them).
//  - Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data): input_step,
//    unsigned Q3.16, always ready; write only while the block is idle.
//    The step is clamped to [0.25, 4.0] in use. Reset value 1.0.
//  - The first two frames after reset only fill the history.
//  - Path of a frame: job queue, back sequencer, pipeline, output register.
//  - Throughput: the back sequencer issues one output per cycle while the
//    receiver does not stall, and passes through idle between input frames;
//    the two-entry job queue lets the front take frames meanwhile.
//  - A stalled receiver freezes the four-stage evaluation pipeline and the
//    sequencer; the queue then fills and o_in_ready drops.
//  - Reset (synchronous, active low) clears history, phase, frame count,
//    queue and all valid flags.
`default_nettype none

module quadratic_audio_resampler #(
    parameter int PHASE_FRAC_BITS = qar_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  qar_pkg::t_in_frame         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output qar_pkg::t_out_frame        o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [PHASE_FRAC_BITS+2:0] i_cfg_data
);
    import qar_pkg::*;

    localparam int PW = PHASE_FRAC_BITS + 3;
    localparam logic [PW-1:0] STEP_RESET = PW'(1) << PHASE_FRAC_BITS;

    logic [PW-1:0] r_input_step;
    logic          w_push, w_pop;
    t_job          w_push_job, w_pop_job;
    t_q_stat       w_q_stat;

    // config register; no side effects beyond the stored step
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_step <= STEP_RESET;
        end else if (i_cfg_valid) begin
            r_input_step <= i_cfg_data;
        end
    end

    // front: history and coefficient jobs
    qar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // decouples the front from the back
    qar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_stat  (w_q_stat)
    );

    // back: phase stepping and evaluation pipeline, owns the output register
    qar_back #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_input_step),
        .i_job       (w_pop_job),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/qar_queue.sv
// Short job queue between the front and back parts of the resampler.
// Depends on qar_pkg.
`default_nettype none

module qar_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qar_pkg::t_job   i_job,
    input  logic            i_pop,
    output qar_pkg::t_job   o_job,
    output qar_pkg::t_q_stat o_stat
);
    import qar_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

>>> hw/rtl/qar_front.sv
// Front part: takes input frames, keeps the history and turns each
// interval into a job of parabola coefficients. Depends on qar_pkg.
`default_nettype none

module qar_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  qar_pkg::t_in_frame i_in_data,
    input  qar_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output qar_pkg::t_job    o_job
);
    import qar_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [1:0] SEEN_FULL = 2'd3;

    // h0 older, h1 newer of the two previous frames
    logic signed [SW-1:0] r_h0_l, r_h1_l, r_h0_r, r_h1_r;
    logic [1:0]           r_seen;
    logic                 w_accept;

    function automatic logic signed [SW+1:0] coef_a2(
        input logic signed [SW-1:0] h0,
        input logic signed [SW-1:0] h1,
        input logic signed [SW-1:0] x
    );
        coef_a2 = {{2{h0[SW-1]}}, h0} - {h1[SW-1], h1, 1'b0} + {{2{x[SW-1]}}, x};
    endfunction

    function automatic logic signed [SW+2:0] coef_b2(
        input logic signed [SW-1:0] h0,
        input logic signed [SW-1:0] h1,
        input logic signed [SW-1:0] x
    );
        coef_b2 = {h1[SW-1], h1, 2'b00} - {{3{h0[SW-1]}}, h0}
                - {{2{h0[SW-1]}}, h0, 1'b0} - {{3{x[SW-1]}}, x};
    endfunction

    assign o_in_ready = !i_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    // the first two frames only fill the history
    assign o_push     = w_accept && r_seen[1];
    assign o_job.first = (r_seen == SEEN_TWO);
    assign o_job.a2_l = coef_a2(r_h0_l, r_h1_l, i_in_data.left_sample);
    assign o_job.b2_l = coef_b2(r_h0_l, r_h1_l, i_in_data.left_sample);
    assign o_job.y0_l = r_h0_l;
    assign o_job.a2_r = coef_a2(r_h0_r, r_h1_r, i_in_data.right_sample);
    assign o_job.b2_r = coef_b2(r_h0_r, r_h1_r, i_in_data.right_sample);
    assign o_job.y0_r = r_h0_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0_l <= '0;
            r_h1_l <= '0;
            r_h0_r <= '0;
            r_h1_r <= '0;
            r_seen <= '0;
        end else if (w_accept) begin
            r_h0_l <= r_h1_l;
            r_h1_l <= i_in_data.left_sample;
            r_h0_r <= r_h1_r;
            r_h1_r <= i_in_data.right_sample;
            if (r_seen != SEEN_FULL) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/qar_back.sv
// Back part: steps the output position across each interval and runs
// the two-lane quadratic evaluation pipeline. Depends on qar_pkg.
`default_nettype none

module qar_back #(
    parameter int PHASE_FRAC_BITS = qar_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [PHASE_FRAC_BITS+2:0] i_step,
    input  qar_pkg::t_job             i_job,
    input  qar_pkg::t_q_stat          i_q_stat,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output qar_pkg::t_out_frame       o_out_data
);
    import qar_pkg::*;

    localparam int F     = PHASE_FRAC_BITS;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = F + 3;
    localparam int TW    = SW + F + 5;
    localparam int SH_U  = F - 8;
    localparam int UW    = TW - SH_U;
    localparam int VW    = UW + F + 2;
    localparam int RW    = VW - F - 9;
    localparam int CNT_W = $clog2(MAX_RESULTS);

    localparam logic [PW-1:0]    ONE      = PW'(1) << F;
    localparam logic [PW-1:0]    LIMIT    = ONE << 1;
    localparam logic [PW-1:0]    STEP_MIN = ONE >> 2;
    localparam logic [PW-1:0]    STEP_MAX = ONE << 2;
    localparam logic [TW-1:0]    RND_U    = (TW'(1) << SH_U) >> 1;
    localparam logic [VW-1:0]    RND_V    = VW'(1) << (F + 8);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state            r_state;
    t_job              r_job;
    logic [PW-1:0]     r_pos;
    logic [F+1:0]      r_phase;
    logic [CNT_W-1:0]  r_cnt;

    // issue stage
    logic                 r_s0_valid, r_s0_last;
    logic [F:0]           r_s0_x;
    logic signed [SW+1:0] r_s0_a2 [2];
    logic signed [SW+2:0] r_s0_b2 [2];
    logic signed [SW-1:0] r_s0_y0 [2];
    // a2*X
    logic                 r_s1_valid, r_s1_last;
    logic [F:0]           r_s1_x;
    logic signed [TW-1:0] r_s1_m1 [2];
    logic signed [SW+2:0] r_s1_b2 [2];
    logic signed [SW-1:0] r_s1_y0 [2];
    // rounded inner term
    logic                 r_s2_valid, r_s2_last;
    logic [F:0]           r_s2_x;
    logic signed [UW-1:0] r_s2_u [2];
    logic signed [SW-1:0] r_s2_y0 [2];
    // u*X
    logic                 r_s3_valid, r_s3_last;
    logic signed [VW-1:0] r_s3_m2 [2];
    logic signed [SW-1:0] r_s3_y0 [2];

    logic       r_out_valid;
    t_out_frame r_out_data;

    logic                 w_en, w_issue, w_issue_last;
    logic [PW-1:0]        w_step, w_next_pos;
    logic signed [TW-1:0] w_t [2];
    logic signed [VW-1:0] w_v [2];
    logic signed [RW-1:0] w_r [2];

    function automatic logic signed [SW-1:0] sat(input logic signed [RW-1:0] r);
        logic fits;
        fits = (&r[RW-1:SW-1]) || !(|r[RW-1:SW-1]);
        sat  = fits ? r[SW-1:0] : {r[RW-1], {(SW-1){~r[RW-1]}}};
    endfunction

    // whole pipeline moves only when the output register can take a request
    assign w_en = !r_out_valid || i_out_ready;

    always_comb begin
        if (i_step < STEP_MIN) begin
            w_step = STEP_MIN;
        end else if (i_step > STEP_MAX) begin
            w_step = STEP_MAX;
        end else begin
            w_step = i_step;
        end
    end

    assign w_next_pos   = r_pos + w_step;
    assign w_issue      = (r_state == S_RUN) && w_en && (r_pos < LIMIT);
    assign w_issue_last = (w_next_pos >= LIMIT) || (r_cnt == CNT_LAST);
    assign o_pop        = (r_state == S_IDLE) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= '0;
            r_s0_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_s0_valid <= w_issue;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_job   <= i_job;
                        r_pos   <= {1'b0, r_phase} + (i_job.first ? '0 : ONE);
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_pos >= LIMIT) begin
                        // no output falls in this interval
                        r_phase <= (F+2)'(r_pos - LIMIT);
                        r_state <= S_IDLE;
                    end else if (w_en) begin
                        r_s0_x     <= r_pos[F:0];
                        r_s0_last  <= w_issue_last;
                        r_s0_a2[0] <= r_job.a2_l;
                        r_s0_b2[0] <= r_job.b2_l;
                        r_s0_y0[0] <= r_job.y0_l;
                        r_s0_a2[1] <= r_job.a2_r;
                        r_s0_b2[1] <= r_job.b2_r;
                        r_s0_y0[1] <= r_job.y0_r;
                        if (w_issue_last) begin
                            r_phase <= (w_next_pos >= LIMIT) ?
                                       (F+2)'(w_next_pos - LIMIT) : '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_pos <= w_next_pos;
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_t[i] = r_s1_m1[i] + {{(TW-SW-3-F){r_s1_b2[i][SW+2]}}, r_s1_b2[i], {F{1'b0}}}
                   + RND_U;
            w_v[i] = r_s3_m2[i] + {{(VW-SW-F-9){r_s3_y0[i][SW-1]}}, r_s3_y0[i], {(F+9){1'b0}}}
                   + RND_V;
            w_r[i] = w_v[i][VW-1:F+9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_x    <= r_s0_x;
            r_s1_last <= r_s0_last;
            r_s2_x    <= r_s1_x;
            r_s2_last <= r_s1_last;
            r_s3_last <= r_s2_last;
            for (int i = 0; i < 2; i++) begin
                r_s1_m1[i] <= TW'(r_s0_a2[i] * $signed({1'b0, r_s0_x}));
                r_s1_b2[i] <= r_s0_b2[i];
                r_s1_y0[i] <= r_s0_y0[i];
                r_s2_u[i]  <= w_t[i][TW-1:SH_U];
                r_s2_y0[i] <= r_s1_y0[i];
                r_s3_m2[i] <= VW'(r_s2_u[i] * $signed({1'b0, r_s2_x}));
                r_s3_y0[i] <= r_s2_y0[i];
            end
            r_out_data.left_out  <= sat(w_r[0]);
            r_out_data.right_out <= sat(w_r[1]);
            r_out_data.last      <= r_s3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_s0_valid) && $stable(r_s3_valid))
        else $error("pipeline moved while output stalled");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_issue_last) |=> (r_state == S_IDLE))
        else $error("sequencer kept running after final output of interval");

    a_stage_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s1_valid) |=> r_s2_valid)
        else $error("request dropped between pipeline stages");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && (r_state == S_IDLE))
        else $error("reset did not clear back part");

endmodule

`default_nettype wire

>>> tb/quadratic_audio_resampler_test.sv
`timescale 1ns / 1ps
// Self-checking bench for quadratic_audio_resampler: random stereo frames and step
// settings, with an in-bench model of the parabola interpolation. Needs qar_pkg and the design modules.
module quadratic_audio_resampler_test;
    import qar_pkg::*;

    localparam int     SW            = qar_pkg::SAMPLE_WIDTH;
    localparam int     F             = qar_pkg::PHASE_FRAC_BITS_DEF;
    localparam longint ONE_POS       = longint'(1) << F;
    localparam longint STEP_MIN      = ONE_POS >> 2;
    localparam longint STEP_MAX      = ONE_POS << 2;
    localparam longint SPAN_END      = 2 * ONE_POS;
    localparam longint SAT_HI        = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAT_LO        = -SAT_HI - 1;
    localparam int     SETTLE_CYCLES = 32;     // frames with no output may still be in flight
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     HOLD_OFF      = 400;
    localparam int     IDLE_PCT      = 21;

    // ---------------------------------------------------------------- clock, reset, DUT
    logic         i_clk     = 1'b0;
    logic         i_rst_n   = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_ready;
    t_in_frame    in_data   = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    t_out_frame   dut_frame;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [F+2:0] cfg_data  = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    quadratic_audio_resampler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (dut_frame),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------- bench state
    t_in_frame    frames_to_send[$];   // stimulus waiting for the driver
    t_out_frame   interp_due[$];       // interpolated frames still to come out
    logic [F+2:0] step_writes[$];      // pending input_step writes
    int           steps_issued   = 0;
    int           steps_accepted = 0;
    int           error_count    = 0;
    bit           sink_hold      = 1'b0;  // long receiver hold-off
    bit           src_hold       = 1'b0;  // sender pause
    bit           steady         = 1'b0;  // no random idling on either side
    t_out_frame   want_frame;
    logic [SW-1:0] prev_l = '0;
    logic [SW-1:0] prev_r = '0;

    // Model copy of the block's state: per-channel history (oldest first), phase of the
    // next output relative to the newest frame, frame count and the current step word.
    longint       hist_l[3];
    longint       hist_r[3];
    longint       phase_acc  = 0;
    int           frames_seen = 0;
    logic [F+2:0] step_word  = (F + 3)'(ONE_POS);

    initial begin
        for (int k = 0; k < 3; k++) begin
            hist_l[k] = 0;
            hist_r[k] = 0;
        end
    end

    // Parabola through y0, y1, y2 evaluated at offset x_pos (fixed point, F fraction bits)
    // from y0, with the same round-half-up steps as the hardware, then saturated.
    function automatic logic [SW-1:0] parabola_at(input longint y0, input longint y1,
                                                  input longint y2, input longint x_pos);
        longint a2, b2, t, u, v, r;
        a2 = y0 - 2 * y1 + y2;
        b2 = -3 * y0 + 4 * y1 - y2;
        t  = a2 * x_pos + b2 * ONE_POS;
        u  = (t + (longint'(1) <<< (F - 9))) >>> (F - 8);
        v  = u * x_pos + 2 * y0 * (ONE_POS <<< 8);
        r  = (v + (longint'(1) <<< (F + 8))) >>> (F + 9);
        if (r > SAT_HI) r = SAT_HI;
        else if (r < SAT_LO) r = SAT_LO;
        return r[SW-1:0];
    endfunction

    // Shift one accepted frame into the history and queue every output whose position
    // falls in the newly covered interval.
    task automatic shift_and_interpolate(input t_in_frame f);
        longint     pos_acc, step_eff;
        bit         opening;
        int         n;
        t_out_frame r;
        hist_l[0] = hist_l[1];
        hist_l[1] = hist_l[2];
        hist_l[2] = longint'($signed(f.left_sample));
        hist_r[0] = hist_r[1];
        hist_r[1] = hist_r[2];
        hist_r[2] = longint'($signed(f.right_sample));
        // stream start: the first two frames only prime the history
        if (frames_seen < 2) begin
            frames_seen++;
            return;
        end
        opening     = (frames_seen == 2);
        frames_seen = 3;
        step_eff = longint'(step_word);
        if (step_eff < STEP_MIN) step_eff = STEP_MIN;
        if (step_eff > STEP_MAX) step_eff = STEP_MAX;
        // opening interval spans offsets [0,2), every later one [1,2)
        pos_acc = phase_acc + (opening ? 0 : ONE_POS);
        n = 0;
        while (pos_acc < SPAN_END && n < MAX_RESULTS) begin
            r.left_out  = parabola_at(hist_l[0], hist_l[1], hist_l[2], pos_acc);
            r.right_out = parabola_at(hist_r[0], hist_r[1], hist_r[2], pos_acc);
            r.last      = (pos_acc + step_eff >= SPAN_END) || (n == MAX_RESULTS - 1);
            interp_due.push_back(r);
            pos_acc += step_eff;
            n++;
        end
        // an interval with no output just pulls the phase back by one frame
        phase_acc = (pos_acc >= SPAN_END) ? pos_acc - SPAN_END : 0;
    endtask

    // ---------------------------------------------------------------- frame driver
    // Predicts on acceptance, then offers the next request unless idling or paused.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                shift_and_interpolate(in_data);
            end
            if (!in_valid || in_ready) begin
                if (frames_to_send.size() > 0 && !src_hold &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    in_data  <= frames_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- step register driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                step_word = cfg_data;
                steps_accepted++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (step_writes.size() > 0) begin
                    cfg_data  <= step_writes.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (interp_due.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected output L=%0d R=%0d last=%0b", $time,
                                 $signed(dut_frame.left_out), $signed(dut_frame.right_out),
                                 dut_frame.last);
                end else begin
                    want_frame = interp_due.pop_front();
                    if (dut_frame.left_out !== want_frame.left_out ||
                        dut_frame.right_out !== want_frame.right_out ||
                        dut_frame.last !== want_frame.last) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: mismatch exp L=%0d R=%0d last=%0b got L=%0d R=%0d last=%0b",
                                     $time, $signed(want_frame.left_out),
                                     $signed(want_frame.right_out), want_frame.last,
                                     $signed(dut_frame.left_out), $signed(dut_frame.right_out),
                                     dut_frame.last);
                    end
                end
            end
            out_ready <= sink_hold ? 1'b0 : (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------- stimulus helpers
    task automatic queue_frame(input logic [SW-1:0] l, input logic [SW-1:0] r);
        t_in_frame f;
        f.left_sample  = l;
        f.right_sample = r;
        frames_to_send.push_back(f);
        prev_l = l;
        prev_r = r;
    endtask

    // Mix of full-range noise, slow wander, rail values and near-zero values.
    function automatic logic [SW-1:0] pick_sample(input logic [SW-1:0] prev);
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return SW'($urandom);
        if (sel < 70) return prev + SW'($urandom_range(0, 511)) - SW'(256);
        if (sel < 85) return $urandom_range(1) ? SW'(SAT_HI) : SW'(SAT_LO);
        return SW'($urandom_range(0, 31)) - SW'(16);
    endfunction

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++)
            queue_frame(pick_sample(prev_l), pick_sample(prev_r));
    endtask

    // Only while idle: nothing queued, nothing in flight.
    task automatic write_step(input logic [F+2:0] value);
        step_writes.push_back(value);
        steps_issued++;
        while (steps_accepted != steps_issued) @(negedge i_clk);
    endtask

    // Wait until every request went in and every expected frame came out, then let
    // frames that produce nothing clear the pipeline.
    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((frames_to_send.size() > 0 || in_valid || interp_due.size() > 0) &&
               guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- test sequence
    initial begin
        logic [F+2:0] step_pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset step (1.0): stream start with rail values; first two frames give nothing.
        queue_frame(16'h0000, 16'h0000);
        queue_frame(16'h7FFF, 16'h8000);
        queue_frame(16'h8000, 16'h7FFF);
        queue_frame(16'h7FFF, 16'h8000);
        queue_frame(16'hFFFF, 16'h0000);
        queue_frame(16'h0000, 16'hFFFF);
        wait_idle();

        // Smallest step: four outputs per interval, overshoot into both rails.
        write_step(19'(STEP_MIN));
        queue_frame(16'h8000, 16'h7FFF);
        queue_frame(16'h7FFF, 16'h8000);
        queue_frame(16'h7FFF, 16'h8000);
        queue_frame(16'h8000, 16'h7FFF);
        queue_frame(16'h3039, 16'hCFC7);
        queue_frame(16'hFFFF, 16'hFFFF);
        wait_idle();

        // Largest step: most intervals yield no output at all.
        write_step(19'(STEP_MAX));
        queue_frame(16'h7FFF, 16'h7FFF);
        queue_frame(16'h8000, 16'h8000);
        queue_frame(16'h5555, 16'hAAAA);
        queue_frame(16'hAAAA, 16'h5555);
        queue_frame(16'h0001, 16'h8001);
        queue_frame(16'h7FFE, 16'h0000);
        wait_idle();

        // Out-of-range steps get clamped: zero and all ones.
        write_step('0);
        queue_frame(16'h8000, 16'h7FFF);
        queue_frame(16'h1234, 16'hEDCB);
        queue_frame(16'h7FFF, 16'h8000);
        wait_idle();
        write_step('1);
        queue_frame(16'h4000, 16'hC000);
        queue_frame(16'hC000, 16'h4000);
        queue_frame(16'h0000, 16'h0000);
        wait_idle();

        // Random phases, each with its own step setting.
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: step_pick = 19'(ONE_POS);                       // reset value
                1: step_pick = 19'd60211;                          // 44.1k to 48k
                2: step_pick = 19'd71331;                          // 48k to 44.1k
                3: step_pick = 19'(ONE_POS >> 1);
                4: step_pick = 19'(ONE_POS + (ONE_POS >> 1));
                5: step_pick = 19'(STEP_MIN - 1);                  // just under the clamp
                6: step_pick = 19'($urandom_range(STEP_MIN, STEP_MAX));
                7: step_pick = 19'(STEP_MAX + 1);                  // just over the clamp
                8: step_pick = 19'($urandom_range(0, (1 << (F + 3)) - 1));
                default: step_pick = 19'd45000;
            endcase
            write_step(step_pick);
            steady = (p == 6);
            if (p == 4) begin
                // sender pauses with everything drained, then carries on
                queue_random(24);
                src_hold = 1'b0;
                while (frames_to_send.size() > 0 || in_valid) @(negedge i_clk);
                src_hold = 1'b1;
                wait_idle();
                src_hold = 1'b0;
                queue_random(24);
            end else begin
                queue_random(48);
            end
            if (p == 2) begin
                // receiver holds off while requests keep coming, so the queue backs up
                sink_hold = 1'b1;
                repeat (HOLD_OFF) @(negedge i_clk);
                sink_hold = 1'b0;
            end
            wait_idle();
        end
        steady = 1'b0;

        if (interp_due.size() > 0) begin
            $display("%0d expected frames never arrived", interp_due.size());
            error_count += interp_due.size();
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/qar_pkg.sv
hw/rtl/qar_queue.sv
hw/rtl/qar_front.sv
hw/rtl/qar_back.sv
hw/rtl/quadratic_audio_resampler.sv
tb/quadratic_audio_resampler_test.sv
